// ===== rtl/gtb_pkg.sv =====
// Shared types and constants for the gray-to-braille cell converter.
// No dependencies; used by gtb_scan, gtb_dots and the top level under rtl/.
package gtb_pkg;

  localparam int MAX_CELLS_WIDE = 256;

  localparam int CFG_W   = 9;
  localparam int PIXEL_W = 8;
  localparam int CODE_W  = 14;
  localparam int DOTS_W  = 6;

  localparam logic [CODE_W-1:0]  BRAILLE_BASE     = 14'h2800;
  localparam logic [PIXEL_W-1:0] DOT_THRESHOLD    = 8'd128;
  localparam logic [CFG_W-1:0]   CELLS_WIDE_RESET = 9'd80;
  localparam logic [CFG_W-1:0]   CELLS_HIGH_RESET = 9'd25;
  localparam logic [CFG_W-1:0]   CELLS_HIGH_MAX   = 9'd256;

  typedef enum logic {
    REG_CELLS_WIDE = 1'b0,
    REG_CELLS_HIGH = 1'b1
  } cfg_reg_t;

  // Per-pixel control carried from the scan counters into the cell stage
  typedef struct packed {
    logic       dot;
    logic [1:0] dot_row;
    logic       right;
    logic       last;
  } pix_ctl_t;

  // Standard braille dot order: rows 0..2 left r / right r+3, row 3 left 6 / right 7
  function automatic logic [2:0] dot_pos(input logic [1:0] row, input logic right);
    logic [2:0] pos;
    if (row == 2'd3) begin
      pos = right ? 3'd7 : 3'd6;
    end else begin
      pos = right ? ({1'b0, row} + 3'd3) : {1'b0, row};
    end
    return pos;
  endfunction

endpackage

// ===== rtl/gtb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gtb_scan.sv =====
// Raster position counters and configuration registers.
// Depends on gtb_pkg.
module gtb_scan #(
  parameter int MAX_CELLS_WIDE = gtb_pkg::MAX_CELLS_WIDE,
  localparam int COL_W  = (MAX_CELLS_WIDE > 0) ? $clog2(2 * MAX_CELLS_WIDE) : 1,
  localparam int ADDR_W = (MAX_CELLS_WIDE > 1) ? $clog2(MAX_CELLS_WIDE) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gtb_pkg::CFG_W-1:0]  cfg_data,
  input  logic [gtb_pkg::PIXEL_W-1:0] pixel,
  input  logic                       accept,
  output gtb_pkg::pix_ctl_t          ctl,
  output logic [ADDR_W-1:0]          addr
);

  localparam int CMP_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;

  logic [gtb_pkg::CFG_W-1:0] cells_wide;
  logic [gtb_pkg::CFG_W-1:0] cells_high;
  logic [COL_W-1:0]          pixel_column;
  logic [1:0]                dot_row;
  logic [7:0]                cell_row;

  logic [COL_W-1:0]          pixel_column_next;
  logic [1:0]                dot_row_next;
  logic [7:0]                cell_row_next;

  logic [CMP_W-1:0]          w_raw;
  logic [CMP_W-1:0]          w_max;
  logic [CMP_W-1:0]          w_eff;
  logic [CMP_W-1:0]          last_col;
  logic [gtb_pkg::CFG_W-1:0] h_last;
  logic                      row_end;
  logic                      frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_wide <= gtb_pkg::CELLS_WIDE_RESET;
      cells_high <= gtb_pkg::CELLS_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (gtb_pkg::cfg_reg_t'(cfg_index))
        gtb_pkg::REG_CELLS_WIDE: cells_wide <= cfg_data;
        gtb_pkg::REG_CELLS_HIGH: cells_high <= cfg_data;
      endcase
    end
  end

  // Clamp width to 1..MAX_CELLS_WIDE and height to 1..256
  always_comb begin
    w_raw = CMP_W'(cells_wide);
    w_max = CMP_W'(MAX_CELLS_WIDE);
    if (w_raw == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_raw > w_max) begin
      w_eff = w_max;
    end else begin
      w_eff = w_raw;
    end
    last_col = (w_eff << 1) - CMP_W'(1);

    if (cells_high == '0) begin
      h_last = '0;
    end else if (cells_high > gtb_pkg::CELLS_HIGH_MAX) begin
      h_last = gtb_pkg::CELLS_HIGH_MAX - 9'd1;
    end else begin
      h_last = cells_high - 9'd1;
    end
  end

  assign row_end   = CMP_W'(pixel_column) >= last_col;
  assign frame_end = {1'b0, cell_row} >= h_last;

  always_comb begin
    pixel_column_next = pixel_column + COL_W'(1);
    dot_row_next      = dot_row;
    cell_row_next     = cell_row;
    if (row_end) begin
      pixel_column_next = '0;
      if (dot_row == 2'd3) begin
        dot_row_next  = 2'd0;
        cell_row_next = frame_end ? 8'd0 : cell_row + 8'd1;
      end else begin
        dot_row_next = dot_row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      dot_row      <= '0;
      cell_row     <= '0;
    end else if (accept) begin
      pixel_column <= pixel_column_next;
      dot_row      <= dot_row_next;
      cell_row     <= cell_row_next;
    end
  end

  always_comb begin
    ctl.dot     = pixel >= gtb_pkg::DOT_THRESHOLD;
    ctl.dot_row = dot_row;
    ctl.right   = pixel_column[0];
    ctl.last    = row_end && frame_end;
  end

  assign addr = ADDR_W'(pixel_column >> 1);

`ifndef ASSERT_OFF
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && row_end && frame_end && dot_row == 2'd3)
      |=> (cell_row == 8'd0 && dot_row == 2'd0 && pixel_column == '0))
    else $error("counters did not restart after the last cell of the frame");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(pixel_column) && $stable(dot_row) && $stable(cell_row)))
    else $error("raster position moved without a pixel transfer");
`endif

endmodule

// ===== rtl/gtb_dots.sv =====
// Cell stage: per-column dot store update, cell assembly and result register.
// Depends on gtb_pkg and gtb_ram.
module gtb_dots #(
  parameter int MAX_CELLS_WIDE = gtb_pkg::MAX_CELLS_WIDE,
  localparam int ADDR_W = (MAX_CELLS_WIDE > 1) ? $clog2(MAX_CELLS_WIDE) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  gtb_pkg::pix_ctl_t            in_ctl,
  input  logic [ADDR_W-1:0]            in_addr,
  output logic                         in_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gtb_pkg::CODE_W-1:0]   braille_code,
  output logic                         last_in_frame
);

  localparam int DW = gtb_pkg::DOTS_W;

  logic              s1_valid;
  gtb_pkg::pix_ctl_t s1_ctl;
  logic [ADDR_W-1:0] s1_addr;
  logic              held;

  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  logic [DW-1:0]     lw_data;

  logic [DW-1:0]     rdata;
  logic [DW-1:0]     old_dots;
  logic [DW-1:0]     base_dots;
  logic [DW-1:0]     new_dots;
  logic [2:0]        pos;
  logic              s1_emit;
  logic              s1_adv;
  logic              we;
  logic [gtb_pkg::CODE_W-1:0] code;

  gtb_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_CELLS_WIDE)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (new_dots),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rdata)
  );

  assign s1_emit = (s1_ctl.dot_row == 2'd3) && s1_ctl.right;
  assign s1_adv  = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign in_free = !s1_valid || s1_adv;

  // Read data misses a write made on the same edge; take the last write instead
  always_comb begin
    old_dots  = (lw_valid && lw_addr == s1_addr) ? lw_data : rdata;
    base_dots = (s1_ctl.dot_row == 2'd0 && !s1_ctl.right) ? '0 : old_dots;
    pos       = gtb_pkg::dot_pos(s1_ctl.dot_row, s1_ctl.right);
    new_dots  = base_dots | (DW'(s1_ctl.dot) << pos);
    we        = s1_adv && (s1_ctl.dot_row != 2'd3);
    code      = gtb_pkg::BRAILLE_BASE | {6'b0, s1_ctl.dot, held, old_dots};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_free) begin
      s1_ctl  <= in_ctl;
      s1_addr <= in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
      held     <= 1'b0;
    end else begin
      if (we) begin
        lw_valid <= 1'b1;
      end
      if (s1_adv && s1_ctl.dot_row == 2'd3 && !s1_ctl.right) begin
        held <= s1_ctl.dot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr <= s1_addr;
      lw_data <= new_dots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      braille_code  <= code;
      last_in_frame <= s1_ctl.last;
    end
  end

`ifndef ASSERT_OFF
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (braille_code[13:8] == 6'h28))
    else $error("result outside the braille block");

  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit && out_valid && !out_ready) |=> (s1_valid && $stable(s1_addr)))
    else $error("finished cell dropped while the result register was full");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_free)
    else $error("cell stage offered space while stalled");
`endif

endmodule

// ===== rtl/gray_to_braille_cells_core.sv =====
// Top level of the gray-to-braille cell converter.
// Depends on gtb_pkg, gtb_scan and gtb_dots (which holds gtb_ram).
//
// Usage:
//   Pixels (8-bit gray) enter in raster order on pixel/pixel_valid/pixel_ready,
//   2*cells_wide per row, 4*cells_high rows per frame. A dot is set at gray >= 128.
//   One result per 2x4 cell leaves on braille_code/last_in_frame with
//   out_valid/out_ready; last_in_frame marks the final cell of the frame.
//   cfg_we/cfg_index/cfg_data write cells_wide (index 0) and cells_high (index 1)
//   while the block is idle; out-of-range values are clamped (0 acts as 1).
// Timing:
//   One pixel per cycle while results are taken. The cell's bottom-right pixel
//   passes the cell stage and result registers before out_valid. The per-column
//   dot store is a RAM with a registered read; a read-modify-write per pixel is
//   covered by a one-entry write bypass, so the store never limits the rate.
// Reset:
//   rst (synchronous) returns position counters to the frame start and restores
//   80 x 25 cells. The dot store is not cleared; each entry is written on a
//   cell's first row before use. When out_ready is low with a result pending,
//   the block still accepts pixels until a second finished cell has to wait.
module gray_to_braille_cells_core #(
  parameter int MAX_CELLS_WIDE = gtb_pkg::MAX_CELLS_WIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gtb_pkg::CFG_W-1:0]     cfg_data,
  input  logic [gtb_pkg::PIXEL_W-1:0]   pixel,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  output logic [gtb_pkg::CODE_W-1:0]    braille_code,
  output logic                          last_in_frame,
  output logic                          out_valid,
  input  logic                          out_ready
);

  localparam int ADDR_W = (MAX_CELLS_WIDE > 1) ? $clog2(MAX_CELLS_WIDE) : 1;

  logic              accept;
  logic              in_free;
  gtb_pkg::pix_ctl_t ctl;
  logic [ADDR_W-1:0] addr;

  assign pixel_ready = in_free;
  assign accept      = pixel_valid && in_free;

  gtb_scan #(
    .MAX_CELLS_WIDE (MAX_CELLS_WIDE)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .accept    (accept),
    .ctl       (ctl),
    .addr      (addr)
  );

  gtb_dots #(
    .MAX_CELLS_WIDE (MAX_CELLS_WIDE)
  ) u_dots (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_ctl        (ctl),
    .in_addr       (addr),
    .in_free       (in_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .braille_code  (braille_code),
    .last_in_frame (last_in_frame)
  );

endmodule

// ===== verif/tb_gray_to_braille_cells_core.sv =====
// Self-checking testbench for gray_to_braille_cells_core: raster pixel stimulus,
// in-bench cell predictor and scoreboard on the braille result stream.
// Depends on rtl/gtb_pkg.sv and the core RTL only.
`timescale 1ns / 100ps

module tb_gray_to_braille_cells_core;

  localparam int SETTLE_CYCLES  = 4;
  localparam int STALL_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 100;

  typedef struct packed {
    logic [gtb_pkg::CODE_W-1:0] code;
    logic                       last;
  } cell_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = gtb_pkg::REG_CELLS_WIDE;
  logic [gtb_pkg::CFG_W-1:0]   cfg_data = '0;
  logic [gtb_pkg::PIXEL_W-1:0] pixel = '0;
  logic                        pixel_valid = 1'b0;
  logic                        pixel_ready;
  logic [gtb_pkg::CODE_W-1:0]  braille_code;
  logic                        last_in_frame;
  logic                        out_valid;
  logic                        out_ready = 1'b0;

  gray_to_braille_cells_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .braille_code (braille_code),
    .last_in_frame(last_in_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies, shared by predictor and generator (only changed while idle)
  logic [gtb_pkg::CFG_W-1:0] cfg_wide = gtb_pkg::CELLS_WIDE_RESET;
  logic [gtb_pkg::CFG_W-1:0] cfg_high = gtb_pkg::CELLS_HIGH_RESET;

  // Predicted cell state
  logic [gtb_pkg::DOTS_W-1:0] dot_mem [gtb_pkg::MAX_CELLS_WIDE];
  logic                       held_dot = 1'b0;
  int                         scan_col = 0, scan_drow = 0, scan_crow = 0;

  // Generator's view of the scan position for pixels queued so far
  int gen_col = 0, gen_drow = 0, gen_crow = 0;

  logic [gtb_pkg::PIXEL_W-1:0] pixel_q [$];
  cell_t                       exp_cells [$];
  cell_t                       oldest_cell;
  int                          pix_queued = 0, pix_accepted = 0;
  int                          err_cnt = 0;
  logic                        pix_taken = 1'b0;

  int   send_idle = 0, recv_idle = 0;
  logic stall_req = 1'b0, stall_done = 1'b0;
  int   stall_left = 0;
  int   stuck_cycles = 0;

  function automatic int eff_cells(input logic [gtb_pkg::CFG_W-1:0] v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int frame_pixels();
    return 8 * eff_cells(cfg_wide, gtb_pkg::MAX_CELLS_WIDE)
             * eff_cells(cfg_high, gtb_pkg::CELLS_HIGH_MAX);
  endfunction

  // Raster counters; a position at or past the last column/cell row counts as last
  function automatic void scan_step(inout int col, inout int drow, inout int crow);
    int w, h;
    w = eff_cells(cfg_wide, gtb_pkg::MAX_CELLS_WIDE);
    h = eff_cells(cfg_high, gtb_pkg::CELLS_HIGH_MAX);
    if (col >= 2 * w - 1) begin
      col = 0;
      if (drow >= 3) begin
        drow = 0;
        crow = (crow >= h - 1) ? 0 : crow + 1;
      end else begin
        drow++;
      end
    end else begin
      col++;
    end
  endfunction

  task automatic predict_pixel(input logic [gtb_pkg::PIXEL_W-1:0] p);
    int                         w, h, cidx;
    logic                       dot, right, row_end, frame_end;
    logic [2:0]                 bitpos;
    logic [gtb_pkg::DOTS_W-1:0] prev;
    cell_t                      c;
    w = eff_cells(cfg_wide, gtb_pkg::MAX_CELLS_WIDE);
    h = eff_cells(cfg_high, gtb_pkg::CELLS_HIGH_MAX);
    dot = (p >= gtb_pkg::DOT_THRESHOLD);
    cidx = scan_col / 2;
    right = (scan_col % 2) == 1;
    row_end = scan_col >= 2 * w - 1;
    frame_end = scan_crow >= h - 1;
    if (scan_drow < 3) begin
      // left dot of the first row opens a fresh cell
      prev = (scan_drow == 0 && !right) ? '0 : dot_mem[cidx];
      bitpos = 3'(right ? scan_drow + 3 : scan_drow);
      dot_mem[cidx] = prev | ({{(gtb_pkg::DOTS_W-1){1'b0}}, dot} << bitpos);
    end else if (!right) begin
      held_dot = dot;
    end else begin
      c.code = gtb_pkg::BRAILLE_BASE | {6'b0, dot, held_dot, dot_mem[cidx]};
      c.last = row_end && frame_end;
      exp_cells.push_back(c);
    end
    scan_step(scan_col, scan_drow, scan_crow);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        pixel       <= pixel_q.pop_front();
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with a one-off long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req && !stall_done) begin
      out_ready  <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= pixel_valid && pixel_ready;
      if (out_valid && out_ready) begin
        if (exp_cells.size() == 0) begin
          $error("unexpected transfer: braille_code %h last_in_frame %b",
                 braille_code, last_in_frame);
          err_cnt++;
        end else begin
          oldest_cell = exp_cells.pop_front();
          if (braille_code !== oldest_cell.code) begin
            $error("braille_code: expected %h, got %h", oldest_cell.code, braille_code);
            err_cnt++;
          end
          if (last_in_frame !== oldest_cell.last) begin
            $error("last_in_frame: expected %b, got %b", oldest_cell.last, last_in_frame);
            err_cnt++;
          end
        end
      end
      if (pixel_valid && pixel_ready) begin
        predict_pixel(pixel);
        pix_accepted++;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_gray_to_braille_cells_core: done, errors");
      $finish;
    end
  end

  function automatic logic [gtb_pkg::PIXEL_W-1:0] rand_pixel();
    logic [31:0] r;
    r = $urandom_range(255);
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      default: return r[gtb_pkg::PIXEL_W-1:0];
    endcase
  endfunction

  task automatic push_pixel(input logic [gtb_pkg::PIXEL_W-1:0] p);
    pixel_q.push_back(p);
    pix_queued++;
    scan_step(gen_col, gen_drow, gen_crow);
  endtask

  task automatic queue_random(input int n);
    repeat (n) push_pixel(rand_pixel());
  endtask

  task automatic pad_to_frame_start();
    while (gen_col != 0 || gen_drow != 0 || gen_crow != 0) push_pixel(rand_pixel());
  endtask

  // Block idle: all pixels taken, all cells out, pipeline drained
  task automatic settle();
    while (pix_accepted != pix_queued || exp_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input gtb_pkg::cfg_reg_t r, input int v);
    logic [31:0] vb;
    vb = v;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= vb[gtb_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (r == gtb_pkg::REG_CELLS_WIDE) cfg_wide = vb[gtb_pkg::CFG_W-1:0];
    else cfg_high = vb[gtb_pkg::CFG_W-1:0];
  endtask

  function automatic int pick_wide();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2, 3: return $urandom_range(2, 4);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic int pick_high();
    case ($urandom_range(7))
      0: return 0;
      1: return 1;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Mostly whole frames with random content; partial tails leave the next
  // segment to change registers mid-frame
  task automatic random_phase(input int target);
    int start, sel;
    start = pix_queued;
    while (pix_queued - start < target) begin
      settle();
      if (gen_drow != 0 && $urandom_range(1) == 1) begin
        while (gen_drow != 0 || gen_col != 0) push_pixel(rand_pixel());
        settle();
      end
      if (gen_drow != 0) begin
        // width change here would read cells whose first row was never stored
        cfg_write(gtb_pkg::REG_CELLS_HIGH, pick_high());
      end else begin
        sel = $urandom_range(4);
        if (sel != 0) cfg_write(gtb_pkg::REG_CELLS_WIDE, pick_wide());
        if (sel != 1) cfg_write(gtb_pkg::REG_CELLS_HIGH, pick_high());
      end
      pad_to_frame_start();
      queue_random($urandom_range(1) * frame_pixels());
      if ($urandom_range(1) == 1) queue_random($urandom_range(1, frame_pixels()));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 34;
    recv_idle = 53;

    // one pixel row at the reset size
    queue_random(2 * eff_cells(cfg_wide, gtb_pkg::MAX_CELLS_WIDE));
    settle();

    // zero acts as one; the first cell takes its top row from the row above
    cfg_write(gtb_pkg::REG_CELLS_WIDE, 0);
    cfg_write(gtb_pkg::REG_CELLS_HIGH, 0);
    repeat (8) push_pixel(8'd255);
    repeat (8) push_pixel(8'd0);
    repeat (4) begin
      push_pixel(8'd128);
      push_pixel(8'd127);
    end
    settle();
    cfg_write(gtb_pkg::REG_CELLS_WIDE, 1);
    cfg_write(gtb_pkg::REG_CELLS_HIGH, 1);

    random_phase(RAND_PER_PHASE);

    send_idle = 53;
    recv_idle = 34;
    settle();
    // keep the sender busy while the receiver holds off
    queue_random(200);
    stall_req = 1'b1;
    random_phase(RAND_PER_PHASE);

    send_idle = 0;
    recv_idle = 0;
    settle();
    pad_to_frame_start();
    settle();
    // tall frame with over-range height, then one cell row with the
    // cell row counter already past the last row
    cfg_write(gtb_pkg::REG_CELLS_WIDE, 0);
    cfg_write(gtb_pkg::REG_CELLS_HIGH, 511);
    queue_random(64);
    settle();
    cfg_write(gtb_pkg::REG_CELLS_HIGH, 1);
    queue_random(8);
    settle();
    // widest row, over-range values clamp
    cfg_write(gtb_pkg::REG_CELLS_WIDE, 511);
    cfg_write(gtb_pkg::REG_CELLS_HIGH, 257);
    queue_random(512);
    settle();
    // narrower rows reuse the entries stored above; stop in the bottom row
    // on an even column
    cfg_write(gtb_pkg::REG_CELLS_WIDE, 4);
    queue_random(20);
    settle();
    // shrink the row there: the bottom row ends with no cell
    cfg_write(gtb_pkg::REG_CELLS_WIDE, 2);
    cfg_write(gtb_pkg::REG_CELLS_HIGH, 2);
    random_phase(RAND_PER_PHASE);

    settle();
    repeat (8) @(posedge clk);
    if (exp_cells.size() != 0) begin
      $error("%0d expected cells never transferred", exp_cells.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_gray_to_braille_cells_core: done, clean");
    end else begin
      $display("tb_gray_to_braille_cells_core: done, errors");
    end
    $finish;
  end

endmodule
